@@ hdl/rmd_pkg.sv @@
// Shared types, constants and step tables for the RIPEMD-160 hash engine.
package rmd_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } t_item;

    typedef logic [31:0] t_block [16];

    localparam logic [3:0] WL [80] = '{
        0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
        7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
        3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
        1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
        4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
    localparam logic [3:0] WR [80] = '{
        5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
        6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
        15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
        8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
        12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
    localparam logic [3:0] RL [80] = '{
        11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
        7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
        11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
        11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
        9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
    localparam logic [3:0] RR [80] = '{
        8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
        9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
        9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
        15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
        8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
    localparam logic [31:0] KL [5] = '{32'h0, 32'h5a827999, 32'h6ed9eba1,
                                      32'h8f1bbcdc, 32'ha953fd4e};
    localparam logic [31:0] KR [5] = '{32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3,
                                      32'h7a6d76e9, 32'h0};

    function automatic logic [31:0] f_rotl(input logic [31:0] x, input logic [3:0] s);
        logic [63:0] d;
        d = {x, x} << s;
        return d[63:32];
    endfunction

    function automatic logic [31:0] f_mix(input logic [2:0] g, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
        logic [31:0] r;
        unique case (g)
            3'd0: r = x ^ y ^ z;
            3'd1: r = (x & y) | (~x & z);
            3'd2: r = (x | ~y) ^ z;
            3'd3: r = (x & z) | (y & ~z);
            default: r = x ^ (y | ~z);
        endcase
        return r;
    endfunction

endpackage

@@ hdl/rmd_queue.sv @@
// Two-entry item queue between the front and the back of the engine.
module rmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rmd_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output rmd_pkg::t_item o_item
);
    import rmd_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];
endmodule

@@ hdl/rmd_core.sv @@
// Byte packer, padding sequencer, compression rounds and digest output.
module rmd_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rmd_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_tvalid,
    input  logic           i_tready,
    output logic [31:0]    o_word,
    output logic [2:0]     o_index,
    output logic           o_last
);
    import rmd_pkg::*;

    typedef enum logic [6:0] {
        S_TAKE = 7'b0000001, S_BYTE = 7'b0000010, S_PAD = 7'b0000100,
        S_LEN  = 7'b0001000, S_CMP = 7'b0010000, S_FIN = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state      r_st;
    logic [31:0] r_blk [16];
    logic [31:0] r_h [5];
    logic [31:0] r_v [10];
    logic [63:0] r_len;
    logic [31:0] r_data;
    logic [2:0]  r_cnt;
    logic        r_lastw, r_padend;
    logic [6:0]  r_j;
    logic [2:0]  r_oi;
    logic [5:0]  pos;
    logic [2:0]  g;
    logic [31:0] tl, tr;
    logic [2:0]  cnt_in;

    assign pos    = r_len[5:0];
    assign g      = r_j[6:4];
    assign cnt_in = (i_item.byte_count > 3'd4) ? 3'd4 : i_item.byte_count;
    assign tl = f_rotl(r_v[0] + f_mix(g, r_v[1], r_v[2], r_v[3]) + r_blk[WL[r_j]]
                       + KL[g], RL[r_j]) + r_v[4];
    assign tr = f_rotl(r_v[5] + f_mix(3'd4 - g, r_v[6], r_v[7], r_v[8])
                       + r_blk[WR[r_j]] + KR[g], RR[r_j]) + r_v[9];
    assign o_pop    = (r_st == S_TAKE) && i_valid;
    assign o_tvalid = r_st == S_OUT;
    assign o_word   = r_h[r_oi];
    assign o_index  = r_oi;
    assign o_last   = r_oi == 3'd4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_TAKE;
            r_len <= 64'd0;
            r_oi  <= 3'd0;
            r_h   <= '{IV0, IV1, IV2, IV3, IV4};
        end else begin
            unique case (r_st)
                S_TAKE: if (i_valid) begin
                    r_data  <= i_item.data_word;
                    r_cnt   <= cnt_in;
                    r_lastw <= i_item.last_word;
                    r_st    <= S_BYTE;
                end
                S_BYTE: if (r_cnt != 3'd0) begin
                    r_blk[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= r_data[7:0];
                    r_data <= r_data >> 8;
                    r_cnt  <= r_cnt - 3'd1;
                    r_len  <= r_len + 64'd1;
                    if (pos == 6'd63) begin
                        r_padend <= 1'b0;
                        r_j      <= 7'd0;
                        r_v      <= '{r_h[0], r_h[1], r_h[2], r_h[3], r_h[4],
                                      r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                        r_st     <= S_CMP;
                    end
                end else begin
                    if (r_lastw) begin
                        r_blk[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= 8'h80;
                        for (int b = 0; b < 4; b++) begin
                            if (b > int'(pos[1:0])) r_blk[pos[5:2]][8*b +: 8] <= 8'h00;
                        end
                        for (int w = 0; w < 16; w++) begin
                            if (w > int'(pos[5:2])) r_blk[w] <= 32'd0;
                        end
                        r_st <= (pos >= 6'd56) ? S_PAD : S_LEN;
                    end else begin
                        r_st <= S_TAKE;
                    end
                end
                S_PAD: begin
                    r_padend <= 1'b1;
                    r_j      <= 7'd0;
                    r_v      <= '{r_h[0], r_h[1], r_h[2], r_h[3], r_h[4],
                                  r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                    r_st     <= S_CMP;
                end
                S_LEN: begin
                    r_blk[14] <= {r_len[28:0], 3'b000};
                    r_blk[15] <= r_len[60:29];
                    r_padend  <= 1'b0;
                    r_lastw   <= 1'b0;
                    r_j       <= 7'd0;
                    r_v       <= '{r_h[0], r_h[1], r_h[2], r_h[3], r_h[4],
                                   r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                    r_st      <= S_FIN;
                end
                S_CMP, S_FIN: begin
                    if (r_j != 7'd80) begin
                        r_v <= '{r_v[4], tl, r_v[1], f_rotl(r_v[2], 4'd10), r_v[3],
                                 r_v[9], tr, r_v[6], f_rotl(r_v[7], 4'd10), r_v[8]};
                        r_j <= r_j + 7'd1;
                    end else begin
                        r_h[0] <= r_h[1] + r_v[2] + r_v[8];
                        r_h[1] <= r_h[2] + r_v[3] + r_v[9];
                        r_h[2] <= r_h[3] + r_v[4] + r_v[5];
                        r_h[3] <= r_h[4] + r_v[0] + r_v[6];
                        r_h[4] <= r_h[0] + r_v[1] + r_v[7];
                        if (r_st == S_FIN) begin
                            r_st <= S_OUT;
                        end else if (r_padend) begin
                            for (int w = 0; w < 14; w++) r_blk[w] <= 32'd0;
                            r_st <= S_LEN;
                        end else begin
                            r_st <= S_BYTE;
                        end
                    end
                end
                S_OUT: if (i_tready) begin
                    r_oi <= r_oi + 3'd1;
                    if (r_oi == 3'd4) begin
                        r_oi  <= 3'd0;
                        r_h   <= '{IV0, IV1, IV2, IV3, IV4};
                        r_len <= 64'd0;
                        r_st  <= S_TAKE;
                    end
                end
                default: r_st <= S_TAKE;
            endcase
        end
    end
endmodule

@@ hdl/ripemd160_hash_engine.sv @@
// RIPEMD-160 hash engine: stream input, queue, compression and digest output.
// Each word is taken from the queue and its valid bytes are packed; a full block is compressed before packing goes on.
// Compression: one left and right step pair per cycle, 80 steps, then a chaining-word update.
// Last word: padding and length fill the final block before the digest items; an extra block comes first if full.
// Reset is synchronous, active low: chaining words return to the initial values.
module ripemd160_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // data_word, byte_count, zero fill
    input  logic        s_axis_tlast,  // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // digest_word, word_index, zero fill
    output logic        m_axis_tlast   // last_result
);
    import rmd_pkg::*;

    t_item       w_in, w_q;
    logic        w_full, w_qv, w_pop;
    logic [31:0] w_word;
    logic [2:0]  w_idx;

    assign w_in = '{s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tlast};
    assign s_axis_tready = !w_full;

    rmd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(s_axis_tvalid && !w_full), .i_item(w_in), .o_full(w_full),
        .i_pop(w_pop), .o_valid(w_qv), .o_item(w_q)
    );

    rmd_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .i_item(w_q),
        .o_pop(w_pop), .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_word(w_word), .o_index(w_idx), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, w_idx, w_word};

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> w_idx == 3'd4) else $error("last");
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_idx <= 3'd4) else $error("index");
    a_nopop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !w_pop) else $error("pop");
endmodule
